// ===== sv/owsm_pkg.sv =====
`default_nettype none
package owsm_pkg;

  localparam int XW = 34;         // CORDIC x/y datapath width
  localparam int ZW = 27;         // CORDIC angle width, degrees with 16 fraction bits
  localparam int MAX_STEPS = 24;
  localparam int CW = 5;          // iteration counter width

  localparam logic [24:0] DEG_90  = 25'd5898240;
  localparam logic [24:0] DEG_180 = 25'd11796480;
  localparam logic [24:0] DEG_270 = 25'd17694720;
  localparam logic [24:0] DEG_360 = 25'd23592960;

  typedef struct packed {
    logic start;
    logic vec_mode;
  } cor_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } cor_stat_t;

  function automatic int clamp_steps(input int n);
    int r;
    r = n;
    if (r < 1) r = 1;
    if (r > MAX_STEPS) r = MAX_STEPS;
    return r;
  endfunction

  // atan(2^-i) in degrees with 16 fraction bits.
  function automatic logic [21:0] atan_deg(input logic [CW-1:0] i);
    logic [21:0] v;
    case (i)
      5'd0:  v = 22'd2949120;
      5'd1:  v = 22'd1740967;
      5'd2:  v = 22'd919880;
      5'd3:  v = 22'd466945;
      5'd4:  v = 22'd234379;
      5'd5:  v = 22'd117304;
      5'd6:  v = 22'd58666;
      5'd7:  v = 22'd29335;
      5'd8:  v = 22'd14668;
      5'd9:  v = 22'd7334;
      5'd10: v = 22'd3667;
      5'd11: v = 22'd1833;
      5'd12: v = 22'd917;
      5'd13: v = 22'd458;
      5'd14: v = 22'd229;
      5'd15: v = 22'd115;
      5'd16: v = 22'd57;
      5'd17: v = 22'd29;
      5'd18: v = 22'd14;
      5'd19: v = 22'd7;
      5'd20: v = 22'd4;
      5'd21: v = 22'd2;
      5'd22: v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== sv/owsm_cordic.sv =====
`default_nettype none
module owsm_cordic #(
  parameter int CORDIC_STEPS = 16
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  owsm_pkg::cor_cmd_t                  cmd,
  input  wire logic signed [owsm_pkg::XW-1:0] x0,
  input  wire logic signed [owsm_pkg::XW-1:0] y0,
  input  wire logic signed [owsm_pkg::ZW-1:0] z0,
  output owsm_pkg::cor_stat_t                 stat,
  output logic signed [owsm_pkg::XW-1:0]      x_out,
  output logic signed [owsm_pkg::ZW-1:0]      z_out,
  output logic signed [owsm_pkg::XW-1:0]      y_out
);

  localparam int N = owsm_pkg::clamp_steps(CORDIC_STEPS);

  logic signed [owsm_pkg::XW-1:0] x_r, y_r, x_nxt, y_nxt, xs, ys;
  logic signed [owsm_pkg::ZW-1:0] z_r, z_nxt, at;
  logic [owsm_pkg::CW-1:0]        cnt_r;
  logic                           busy_r, done_r, mode_r, ccw;

  // One micro-rotation per cycle; vectoring drives y to zero, rotation drives z to zero.
  always_comb begin
    xs = x_r >>> cnt_r;
    ys = y_r >>> cnt_r;
    at = {{(owsm_pkg::ZW-22){1'b0}}, owsm_pkg::atan_deg(cnt_r)};
    ccw = mode_r ? !(!y_r[owsm_pkg::XW-1] && (|y_r)) : !z_r[owsm_pkg::ZW-1];
    if (ccw) begin
      x_nxt = x_r - ys;
      y_nxt = y_r + xs;
      z_nxt = z_r - at;
    end else begin
      x_nxt = x_r + ys;
      y_nxt = y_r - xs;
      z_nxt = z_r + at;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      mode_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (cmd.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        mode_r <= cmd.vec_mode;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == owsm_pkg::CW'(N - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      x_r <= x0;
      y_r <= y0;
      z_r <= z0;
    end else if (busy_r) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign x_out = x_r;
  assign y_out = y_r;
  assign z_out = z_r;

endmodule
`default_nettype wire

// ===== sv/omni_wheel_speed_mixer.sv =====
`default_nettype none
// Speed mixer for a three-wheel omni drive.
// The input channel (in_*) carries one transaction per command: in_tuser is the
// operation (drive or stop) and in_tdata the drive vector. For a drive command the
// block finds heading and length of the vector with a CORDIC, then for each wheel
// the relative speed from the heading and the wheel's angle, and scales it by the
// length and the gain. The output channel (out_*) returns exactly one transaction
// per command with the three signed speeds, inverted PWM values and reverse bits.
// One CORDIC unit is shared by the vectoring pass and up to three sine passes, and
// one 32x32 multiplier by all scaling steps. Only one command is in flight:
// in_tready is high only while the sequencer is idle. A finished result sits in the
// output register; a stalled receiver holds it there, and the next command is taken
// meanwhile but cannot finish until the slot frees. Configuration writes go through
// cfg_we/cfg_index/cfg_wdata; the user must issue them only while idle, as the block
// itself does not enforce this. Reset (rst_n low, synchronous) restores the default
// wheel angles 0, 120 and 240, a gain of 1.0, clears the remembered relative speeds
// and empties the output.
module omni_wheel_speed_mixer #(
  parameter int CORDIC_STEPS = 16,
  parameter int PWM_FULL     = 255
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [31:0] in_tdata,    // x_in[15:0], y_in[31:16]
  input  wire  [0:0]  in_tuser,    // op[0]
  output logic        out_tvalid,
  input  wire         out_tready,
  // speed_a[15:0], speed_b[31:16], speed_c[47:32], pwm_a[55:48], pwm_b[63:56],
  // pwm_c[71:64], rev_a[72], rev_b[73], rev_c[74], zero[79:75]
  output logic [79:0] out_tdata,
  input  wire         cfg_we,
  input  wire  [1:0]  cfg_index,
  input  wire  [15:0] cfg_wdata
);

  localparam int XW = owsm_pkg::XW;
  localparam int ZW = owsm_pkg::ZW;
  localparam int Ns = owsm_pkg::clamp_steps(CORDIC_STEPS);
  localparam logic [63:0] Invk = 64'd652032875 + (64'd434688583 >> (2 * Ns));
  localparam logic [16:0] PwmFull = 17'(PWM_FULL);

  localparam logic [1:0] REG_A = 2'd0, REG_B = 2'd1, REG_C = 2'd2, REG_GAIN = 2'd3;

  localparam logic [3:0] S_IDLE = 4'd0, S_VEC = 4'd1, S_LEN = 4'd2, S_LG = 4'd3,
                         S_DIFF = 4'd4, S_SEL = 4'd5, S_ROT = 4'd6, S_MLO = 4'd7,
                         S_MHI = 4'd8, S_OUT = 4'd9;

  logic [3:0]  state_r, state_nxt;
  logic [8:0]  ang_a_r, ang_b_r, ang_c_r;
  logic [15:0] gain_r;
  logic signed [15:0] rel_r [3];
  logic signed [15:0] spd_r [3];
  logic [1:0]  w_r;
  logic [24:0] heading_r, df_r, db_r;
  logic [30:0] len_r;
  logic [46:0] lg_r, acc_r;
  logic        neg_r;
  logic        out_tvalid_r;
  logic [79:0] out_tdata_r;

  wire accept = in_tvalid && in_tready;
  wire signed [15:0] x_in = in_tdata[15:0];
  wire signed [15:0] y_in = in_tdata[31:16];

  // Shared CORDIC.
  owsm_pkg::cor_cmd_t  cor_cmd;
  owsm_pkg::cor_stat_t cor_stat;
  logic signed [XW-1:0] cx0, cy0, cx, cy;
  logic signed [ZW-1:0] cz0, cz;

  owsm_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk(clk), .rst_n(rst_n), .cmd(cor_cmd), .x0(cx0), .y0(cy0), .z0(cz0),
    .stat(cor_stat), .x_out(cx), .z_out(cz), .y_out(cy)
  );

  // Vector scaled by 2^14; the CORDIC control below folds it into the right half plane.
  logic signed [XW-1:0] xv, yv;
  assign xv = {{(XW-30){x_in[15]}}, x_in, 14'd0};
  assign yv = {{(XW-30){y_in[15]}}, y_in, 14'd0};

  // Wheel angle compare for the current wheel.
  logic [8:0]  wsel, fwd;
  logic [9:0]  bsum;
  logic [8:0]  bwd;
  logic [24:0] fq, bq, dfa, dba, df, db;
  always_comb begin
    case (w_r)
      2'd0:    wsel = ang_a_r;
      2'd1:    wsel = ang_b_r;
      default: wsel = ang_c_r;
    endcase
    fwd  = (wsel >= 9'd360) ? wsel - 9'd360 : wsel;
    bsum = {1'b0, fwd} + 10'd180;
    bwd  = (bsum >= 10'd360) ? 9'(bsum - 10'd360) : bsum[8:0];
    fq   = {fwd, 16'd0};
    bq   = {bwd, 16'd0};
    dfa  = (fq > heading_r) ? fq - heading_r : heading_r - fq;
    dba  = (bq > heading_r) ? bq - heading_r : heading_r - bq;
    df   = (dfa > owsm_pkg::DEG_180) ? owsm_pkg::DEG_360 - dfa : dfa;
    db   = (dba > owsm_pkg::DEG_180) ? owsm_pkg::DEG_360 - dba : dba;
  end

  wire take_f = df_r < owsm_pkg::DEG_90;
  wire take_b = db_r < owsm_pkg::DEG_90;

  // Control for the CORDIC.
  always_comb begin
    cor_cmd.start    = 1'b0;
    cor_cmd.vec_mode = 1'b1;
    cx0 = xv;
    cy0 = yv;
    cz0 = '0;
    if (state_r == S_IDLE) begin
      cor_cmd.start = accept && !in_tuser[0] && ((|x_in) || (|y_in));
      if (x_in[15]) begin
        if (!y_in[15]) begin
          cx0 = yv;
          cy0 = -xv;
          cz0 = ZW'(owsm_pkg::DEG_90);
        end else begin
          cx0 = -yv;
          cy0 = xv;
          cz0 = -ZW'(owsm_pkg::DEG_90);
        end
      end
    end else begin
      cor_cmd.vec_mode = 1'b0;
      cor_cmd.start    = (state_r == S_SEL) && (take_f || take_b);
      cx0 = XW'(Invk[29:0]);
      cy0 = '0;
      cz0 = ZW'(owsm_pkg::DEG_90 - (take_f ? df_r : db_r));
    end
  end

  // Heading from the vectoring angle, wrapped into 0..360.
  logic signed [ZW-1:0] hsum;
  logic [24:0] heading;
  assign hsum = cz + ZW'(owsm_pkg::DEG_270);
  assign heading = (hsum >= ZW'(owsm_pkg::DEG_360)) ? 25'(hsum - ZW'(owsm_pkg::DEG_360))
                                                    : 25'(hsum);

  // Sine result clamped to unsigned Q0.15; a negative result gives zero.
  logic signed [18:0] ysh;
  logic [14:0] sine;
  assign ysh = 19'(cy >>> 15);
  assign sine = cy[XW-1] ? 15'd0 : ((ysh > 19'sd32767) ? 15'd32767 : ysh[14:0]);

  // Shared multiplier.
  logic signed [15:0] rel_w;
  logic [14:0] absrel;
  logic [31:0] ma, mb;
  logic [63:0] prod;
  assign rel_w  = rel_r[w_r];
  assign absrel = rel_w[15] ? 15'(-rel_w) : rel_w[14:0];
  always_comb begin
    case (state_r)
      S_LEN:   begin ma = cx[XW-1] ? 32'd0 : cx[31:0]; mb = Invk[31:0]; end
      S_LG:    begin ma = {1'b0, len_r};               mb = {16'd0, gain_r}; end
      S_MLO:   begin ma = lg_r[31:0];                  mb = {17'd0, absrel}; end
      default: begin ma = {17'd0, lg_r[46:32]};        mb = {17'd0, absrel}; end
    endcase
    prod = ma * mb;
  end

  logic [61:0] msum;
  logic [24:0] mag;
  logic signed [15:0] spd;
  assign msum = {15'd0, acc_r} + {prod[29:0], 32'd0};
  assign mag  = msum[61:37];
  assign spd  = rel_w[15] ? ((mag > 25'd32768) ? 16'sh8000 : 16'(25'd0 - mag))
                          : ((mag > 25'd32767) ? 16'sh7fff : mag[15:0]);

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (accept) begin
        if (in_tuser[0])           state_nxt = S_OUT;
        else if (cor_cmd.start)    state_nxt = S_VEC;
        else                       state_nxt = S_LG;
      end
      S_VEC:  if (cor_stat.done) state_nxt = S_LEN;
      S_LEN:  state_nxt = S_LG;
      S_LG:   state_nxt = S_DIFF;
      S_DIFF: state_nxt = S_SEL;
      S_SEL:  state_nxt = (take_f || take_b) ? S_ROT : S_MLO;
      S_ROT:  if (cor_stat.done) state_nxt = S_MLO;
      S_MLO:  state_nxt = S_MHI;
      S_MHI:  state_nxt = (w_r == 2'd2) ? S_OUT : S_DIFF;
      S_OUT:  if (!out_tvalid_r || out_tready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_tready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ang_a_r <= 9'd0;
      ang_b_r <= 9'd120;
      ang_c_r <= 9'd240;
      gain_r  <= 16'd256;
      rel_r[0] <= '0;
      rel_r[1] <= '0;
      rel_r[2] <= '0;
      w_r <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_A:    ang_a_r <= cfg_wdata[8:0];
          REG_B:    ang_b_r <= cfg_wdata[8:0];
          REG_C:    ang_c_r <= cfg_wdata[8:0];
          REG_GAIN: gain_r  <= cfg_wdata;
          default:  gain_r  <= gain_r;
        endcase
      end
      if (state_r == S_LG) w_r <= '0;
      if (state_r == S_MHI) w_r <= w_r + 2'd1;
      if (state_r == S_ROT && cor_stat.done)
        rel_r[w_r] <= neg_r ? -$signed({1'b0, sine}) : $signed({1'b0, sine});
      if (state_r == S_OUT && (!out_tvalid_r || out_tready)) out_tvalid_r <= 1'b1;
      else if (out_tready) out_tvalid_r <= 1'b0;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && accept) begin
      heading_r <= owsm_pkg::DEG_270;
      len_r     <= '0;
      if (in_tuser[0]) begin
        spd_r[0] <= '0;
        spd_r[1] <= '0;
        spd_r[2] <= '0;
      end
    end
    if (state_r == S_VEC && cor_stat.done) heading_r <= heading;
    if (state_r == S_LEN) len_r <= prod[60:30];
    if (state_r == S_LG)  lg_r  <= prod[46:0];
    if (state_r == S_DIFF) begin
      df_r <= df;
      db_r <= db;
    end
    if (state_r == S_SEL) neg_r <= !take_f;
    if (state_r == S_MLO) acc_r <= prod[46:0];
    if (state_r == S_MHI) spd_r[w_r] <= spd;
  end

  // Output register with PWM and reverse bits.
  logic [16:0] smag [3];
  logic [7:0]  pwm [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      smag[k] = spd_r[k][15] ? 17'(-{spd_r[k][15], spd_r[k]}) : {1'b0, spd_r[k]};
      if (PwmFull <= smag[k])                   pwm[k] = 8'd0;
      else if ((PwmFull - smag[k]) > 17'd255)   pwm[k] = 8'd255;
      else                                      pwm[k] = 8'(PwmFull - smag[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_OUT && (!out_tvalid_r || out_tready))
      out_tdata_r <= {5'd0, spd_r[2][15], spd_r[1][15], spd_r[0][15],
                      pwm[2], pwm[1], pwm[0], spd_r[2], spd_r[1], spd_r[0]};
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // The CORDIC only works while the sequencer waits on it.
  a_cordic_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !cor_stat.busy) else $error("CORDIC busy while idle");
  a_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    cor_stat.done |-> (state_r == S_VEC || state_r == S_ROT))
    else $error("CORDIC finished outside a wait state");
  a_rel_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(state_r == S_ROT && cor_stat.done) |=>
      ($stable(rel_r[0]) && $stable(rel_r[1]) && $stable(rel_r[2])))
    else $error("relative speed changed without a sine pass");
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> $past(state_r) == S_OUT)
    else $error("result presented outside the output step");

endmodule
`default_nettype wire
